// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Clock and reset names are fixed by the house convention: clk, rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ELV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ELV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/elv_pkg.sv
// ----------------------------------------------------------------------------
// elv_pkg
// Shared types, character codes, status codes and byte classes for the
// env line validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package elv_pkg;

    localparam int MAX_LINE_LEN_DEF = 4096;

    // result field widths
    localparam int STATUS_W = 4;
    localparam int KLEN_W   = 12;
    localparam int RAW_W    = 12;
    localparam int VSTART_W = 13;
    localparam int VLEN_W   = 12;
    localparam int M_DATA_W = 56;   // 49 bits of fields, padded to bytes

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_US    = 8'h5F;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP       = 4'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_EQUALS  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_KEY  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_KEY_LEAD   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_KEY_TRAIL  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_KEY_BAD    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_VAL_LEAD   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_DQ_OPEN    = 4'd9;
    localparam logic [STATUS_W-1:0] ST_SQ_OPEN    = 4'd10;
    localparam logic [STATUS_W-1:0] ST_TRAILING   = 4'd11;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 4'd12;

    // per-line flags and captured bytes (positions travel separately)
    typedef struct packed {
        logic       seen_equals;
        logic       blank_so_far;
        logic       nul_seen;
        logic       key_bad;
        logic       close_quote_seen;
        logic       value_bad_char;
        logic       overflowed;
        logic [7:0] first_line_byte;
        logic [7:0] key_last_byte;
        logic [7:0] previous_byte;
        logic [7:0] value_first_byte;
    } line_flags_t;

    localparam line_flags_t FLAGS_CLEAR = '{
        seen_equals:      1'b0,
        blank_so_far:     1'b1,
        nul_seen:         1'b0,
        key_bad:          1'b0,
        close_quote_seen: 1'b0,
        value_bad_char:   1'b0,
        overflowed:       1'b0,
        first_line_byte:  8'h00,
        key_last_byte:    8'h00,
        previous_byte:    8'h00,
        value_first_byte: 8'h00
    };

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KLEN_W-1:0]   key_length;
        logic [RAW_W-1:0]    raw_value_length;
        logic [VSTART_W-1:0] value_start;
        logic [VLEN_W-1:0]   value_length;
    } line_result_t;

    function automatic logic is_sp_tab(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQ) || (c == CH_SQ);
    endfunction

endpackage

`default_nettype wire

// File: hdl/elv_line_state.sv
// ----------------------------------------------------------------------------
// elv_line_state
// Per-line tracking registers; folds one byte into the line state per step
// and presents the updated state for the end-of-line check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module elv_line_state
    import elv_pkg::*;
#(
    parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF,
    localparam int PW          = $clog2(MAX_LINE_LEN + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,        // process the held item
    input  wire logic [7:0]        data_byte,
    input  wire logic              has_byte,
    input  wire logic              end_of_line,
    output line_flags_t            upd_flags,   // state after this byte
    output logic [PW-1:0]          upd_pos,
    output logic [PW-1:0]          upd_key_len,
    output logic [PW-1:0]          upd_cq_pos
);

    localparam logic [PW-1:0] MAX_POS = PW'(MAX_LINE_LEN);

    line_flags_t   flags_reg, flags_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] key_len_reg, key_len_next;
    logic [PW-1:0] cq_pos_reg, cq_pos_next;

    logic          first_value_byte;
    logic          key_ok;

    assign first_value_byte = ({1'b0, pos_reg} == ({1'b0, key_len_reg} + (PW+1)'(1)));
    assign key_ok = (pos_reg == '0) ? (is_alpha(data_byte) || (data_byte == CH_US))
                                    : (is_alpha(data_byte) || is_digit(data_byte) ||
                                       (data_byte == CH_US));

    // fold in the byte
    always_comb
    begin
        upd_flags   = flags_reg;
        upd_pos     = pos_reg;
        upd_key_len = key_len_reg;
        upd_cq_pos  = cq_pos_reg;
        if (has_byte)
        begin
            if (pos_reg >= MAX_POS)
            begin
                upd_flags.overflowed = 1'b1;
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    upd_flags.first_line_byte = data_byte;
                end
                else if (!is_sp_tab(flags_reg.previous_byte))
                begin
                    upd_flags.blank_so_far = 1'b0;
                end
                if (data_byte == CH_NUL)
                begin
                    upd_flags.nul_seen = 1'b1;
                end
                if (!flags_reg.seen_equals)
                begin
                    if (data_byte == CH_EQ)
                    begin
                        upd_flags.seen_equals = 1'b1;
                        upd_key_len           = pos_reg;
                    end
                    else
                    begin
                        if (!key_ok)
                        begin
                            upd_flags.key_bad = 1'b1;
                        end
                        upd_flags.key_last_byte = data_byte;
                    end
                end
                else
                begin
                    if (first_value_byte)
                    begin
                        upd_flags.value_first_byte = data_byte;
                    end
                    else if (is_quote(flags_reg.value_first_byte) &&
                             (data_byte == flags_reg.value_first_byte) &&
                             !flags_reg.close_quote_seen)
                    begin
                        upd_flags.close_quote_seen = 1'b1;
                        upd_cq_pos                 = pos_reg;
                    end
                    if (is_sp_tab(data_byte) || is_quote(data_byte) ||
                        (data_byte == CH_BSL))
                    begin
                        upd_flags.value_bad_char = 1'b1;
                    end
                end
                upd_flags.previous_byte = data_byte;
                upd_pos                 = pos_reg + PW'(1);
            end
        end
    end

    // commit, or start a fresh line after the close
    always_comb
    begin
        flags_next   = flags_reg;
        pos_next     = pos_reg;
        key_len_next = key_len_reg;
        cq_pos_next  = cq_pos_reg;
        if (step)
        begin
            if (end_of_line)
            begin
                flags_next   = FLAGS_CLEAR;
                pos_next     = '0;
                key_len_next = '0;
                cq_pos_next  = '0;
            end
            else
            begin
                flags_next   = upd_flags;
                pos_next     = upd_pos;
                key_len_next = upd_key_len;
                cq_pos_next  = upd_cq_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= FLAGS_CLEAR;
            pos_reg     <= '0;
            key_len_reg <= '0;
            cq_pos_reg  <= '0;
        end
        else
        begin
            flags_reg   <= flags_next;
            pos_reg     <= pos_next;
            key_len_reg <= key_len_next;
            cq_pos_reg  <= cq_pos_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/elv_judge.sv
// ----------------------------------------------------------------------------
// elv_judge
// End-of-line verdict: priority-ordered checks and value bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module elv_judge
    import elv_pkg::*;
#(
    parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF,
    localparam int PW          = $clog2(MAX_LINE_LEN + 1)
)
(
    input  wire logic              shell_mode,
    input  wire line_flags_t       flags,
    input  wire logic [PW-1:0]     pos,
    input  wire logic [PW-1:0]     key_len,
    input  wire logic [PW-1:0]     cq_pos,
    output line_result_t           result
);

    logic          cr_end;
    logic          blank;
    logic          eff_empty;
    logic [PW-1:0] raw_len;
    logic [PW-1:0] vstart_plain;
    logic [PW-1:0] vstart_quoted;
    logic [PW-1:0] vlen_quoted;
    logic          quoted;

    assign cr_end        = (flags.previous_byte == CH_CR);
    assign eff_empty     = cr_end && (pos == PW'(1));
    assign blank         = cr_end ? flags.blank_so_far
                                  : (flags.blank_so_far && is_sp_tab(flags.previous_byte));
    assign raw_len       = pos - key_len - PW'(1);
    assign vstart_plain  = key_len + PW'(1);
    assign vstart_quoted = key_len + PW'(2);
    assign vlen_quoted   = cq_pos - key_len - PW'(2);
    assign quoted        = shell_mode && (raw_len != '0) && is_quote(flags.value_first_byte);

    always_comb
    begin
        result = '0;
        if (flags.overflowed)
            result.status = ST_TOO_LONG;
        else if ((pos == '0) || eff_empty || (flags.first_line_byte == CH_HASH) || blank)
            result.status = ST_SKIP;
        else if (flags.nul_seen)
            result.status = ST_BAD_CHAR;
        else if (!flags.seen_equals)
            result.status = ST_NO_EQUALS;
        else if (key_len == '0)
            result.status = ST_EMPTY_KEY;
        else if (shell_mode && is_sp_tab(flags.first_line_byte))
            result.status = ST_KEY_LEAD;
        else if (shell_mode && is_sp_tab(flags.key_last_byte))
            result.status = ST_KEY_TRAIL;
        else if (shell_mode && flags.key_bad)
            result.status = ST_KEY_BAD;
        else if (shell_mode && (raw_len != '0) && is_sp_tab(flags.value_first_byte))
            result.status = ST_VAL_LEAD;
        else if (quoted && !flags.close_quote_seen)
            result.status = (flags.value_first_byte == CH_DQ) ? ST_DQ_OPEN : ST_SQ_OPEN;
        else if (quoted && ((cq_pos + PW'(1)) != pos))
            result.status = ST_TRAILING;
        else if (shell_mode && (raw_len != '0) && !quoted && flags.value_bad_char)
            result.status = ST_BAD_CHAR;
        else
        begin
            result.status           = ST_OK;
            result.key_length       = KLEN_W'(key_len);
            result.raw_value_length = RAW_W'(raw_len);
            result.value_start      = quoted ? VSTART_W'(vstart_quoted)
                                             : VSTART_W'(vstart_plain);
            result.value_length     = quoted ? VLEN_W'(vlen_quoted) : VLEN_W'(raw_len);
        end
    end

endmodule

`default_nettype wire

// File: hdl/env_line_validator_top.sv
// Env line validator: takes one line of an environment file a byte per
// transaction and closes it on tlast, returning one result transaction per line
// (status in m_tuser, key and value bounds in m_tdata, bounds zero unless the
// status is ok). One transaction is taken every clock cycle; a closing
// transaction's result is registered, and the input stalls only when a closing
// transaction is held while a result is waiting in that register and m_tready
// is low. The per-byte state update plus the end-of-line checks form the single
// combinational step between the input register and the result register, which
// sets that rate. shell_mode is sampled when a line closes; the user must ensure
// it is written only while no line is open, which the block does not enforce.
// ----------------------------------------------------------------------------
// env_line_validator_top
// Stream front end: input register, line tracker, verdict logic, result
// register, mode register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module env_line_validator_top
    import elv_pkg::*;
#(
    parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // byte stream in
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
    input  wire logic                s_tuser,   // [0] has_byte
    input  wire logic                s_tlast,   // end_of_line
    // line results out
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [11:0] key_length,
                                                // [23:12] raw_value_length,
                                                // [36:24] value_start,
                                                // [48:37] value_length, rest 0
    output logic [STATUS_W-1:0]      m_tuser,   // [3:0] status
    // mode register write
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data   // shell_mode
);

    localparam int PW = $clog2(MAX_LINE_LEN + 1);

    // input register
    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_has_reg;
    logic          in_eol_reg;

    // result register
    logic          out_valid_reg, out_valid_next;
    line_result_t  out_res_reg;

    logic          shell_mode_reg, shell_mode_next;

    logic          advance;
    logic          close_line;
    line_flags_t   upd_flags;
    logic [PW-1:0] upd_pos;
    logic [PW-1:0] upd_key_len;
    logic [PW-1:0] upd_cq_pos;
    line_result_t  judge_res;

    // A closing transaction needs a free result slot; other bytes never wait.
    assign advance    = in_valid_reg && (!in_eol_reg || !out_valid_reg || m_tready);
    assign close_line = advance && in_eol_reg;
    assign s_tready   = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign in_valid_next   = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next  = close_line ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign shell_mode_next = cfg_valid ? cfg_data : shell_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            shell_mode_reg <= 1'b1;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            shell_mode_reg <= shell_mode_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_eol_reg  <= s_tlast;
        end
        if (close_line)
        begin
            out_res_reg <= judge_res;
        end
    end

    elv_line_state #(
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (in_byte_reg),
        .has_byte     (in_has_reg),
        .end_of_line  (in_eol_reg),
        .upd_flags    (upd_flags),
        .upd_pos      (upd_pos),
        .upd_key_len  (upd_key_len),
        .upd_cq_pos   (upd_cq_pos)
    );

    elv_judge #(
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_judge (
        .shell_mode   (shell_mode_reg),
        .flags        (upd_flags),
        .pos          (upd_pos),
        .key_len      (upd_key_len),
        .cq_pos       (upd_cq_pos),
        .result       (judge_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {{(M_DATA_W - KLEN_W - RAW_W - VSTART_W - VLEN_W){1'b0}},
                       out_res_reg.value_length,
                       out_res_reg.value_start,
                       out_res_reg.raw_value_length,
                       out_res_reg.key_length};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `ELV_ASSERT(a_close_gives_result, close_line |=> m_tvalid, "closed line gave no result")
    `ELV_ASSERT(a_fail_zero_bounds, m_tvalid && m_tuser != ST_OK |-> m_tdata == '0, "bad bounds")
    `ELV_ASSERT(a_status_range, m_tvalid |-> (m_tuser <= ST_TOO_LONG), "status code out of range")
    `ELV_ASSERT_ALWAYS(a_reset_idle, $rose(rst_n) |-> !m_tvalid && s_tready, "not idle after reset")

endmodule

`default_nettype wire
